// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the sorted priority queue.
// SPQ_ASSERT is disabled while reset is asserted; SPQ_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SPQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spq assertion failed");

`define SPQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("spq assertion failed");

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Operation and status codes and the control struct of the queue cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Broadcast to every cell: at most one of the two is set in a cycle.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded min-priority queue built as a shift-register chain of sorted cells.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low; op_i selects insert or remove, and the key and handle ports carry the
// entry for an insert. busy is held low, because every request is finished
// in the cycle it is taken, so a new request may follow every cycle.
// The result appears in the cycle after the request, for one cycle only, marked
// by done_o; the receiver cannot stall it and must take it then.
// Entries are kept in a row of CAPACITY cells, the head in cell 0. On insert
// every cell compares the new key with its own entry at once; the cells from
// the insertion point onwards take their left neighbour's entry, and the cell
// at that point takes the new one, so equal keys leave first in, first out.
// On remove every cell takes its right neighbour's entry and cell 0 is
// reported. A remove from an empty queue reports status one; an insert into a
// full queue reports status two and drops the entry.
// The throughput is one request per cycle. Reset clears the entry count
// and the done flag; the cell contents are left as they are, and slots
// beyond the count are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int WEIGHT_BITS = 32,
  parameter int HANDLE_BITS = 9,
  localparam int CNT_BITS   = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   op_i,
  input  wire logic [WEIGHT_BITS-1:0] key_weight_i,
  input  wire logic [7:0]             key_symbol_i,
  input  wire logic [HANDLE_BITS-1:0] item_handle_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [HANDLE_BITS-1:0]      out_handle_o,
  output logic [WEIGHT_BITS-1:0]      out_weight_o,
  output logic [7:0]                  out_symbol_o,
  output logic [CNT_BITS-1:0]         occupancy_o,
  output logic                        is_empty_o,
  output logic                        size_is_one_o
);

  localparam logic [CNT_BITS-1:0] CountFull = CNT_BITS'(CAPACITY);
  localparam logic [CNT_BITS-1:0] CountOne  = CNT_BITS'(1);

  logic [CNT_BITS-1:0]    count_q, count_d;
  logic                   done_q;
  logic [1:0]             status_q, status_d;
  logic [WEIGHT_BITS-1:0] res_weight_q, res_weight_d;
  logic [7:0]             res_symbol_q, res_symbol_d;
  logic [HANDLE_BITS-1:0] res_handle_q, res_handle_d;
  logic                   accept;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;

  // Chain wires between the cells.
  logic                   move_chain   [CAPACITY];
  logic [WEIGHT_BITS-1:0] weight_chain [CAPACITY];
  logic [7:0]             symbol_chain [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_chain [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_q == CountFull;
  assign empty  = count_q == '0;

  assign ctrl.insert = accept && (op_i == OP_INSERT) && !full;
  assign ctrl.remove = accept && (op_i == OP_REMOVE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_move;
    logic [WEIGHT_BITS-1:0] left_weight, right_weight;
    logic [7:0]             left_symbol, right_symbol;
    logic [HANDLE_BITS-1:0] left_handle, right_handle;

    if (i == 0) begin : g_head
      assign left_move   = 1'b0;
      assign left_weight = '0;
      assign left_symbol = '0;
      assign left_handle = '0;
    end else begin : g_mid
      assign left_move   = move_chain[i-1];
      assign left_weight = weight_chain[i-1];
      assign left_symbol = symbol_chain[i-1];
      assign left_handle = handle_chain[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_weight = '0;
      assign right_symbol = '0;
      assign right_handle = '0;
    end else begin : g_body
      assign right_weight = weight_chain[i+1];
      assign right_symbol = symbol_chain[i+1];
      assign right_handle = handle_chain[i+1];
    end

    spq_cell #(
      .IDX         (i),
      .CNT_BITS    (CNT_BITS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .count_i        (count_q),
      .new_weight_i   (key_weight_i),
      .new_symbol_i   (key_symbol_i),
      .new_handle_i   (item_handle_i),
      .left_move_i    (left_move),
      .left_weight_i  (left_weight),
      .left_symbol_i  (left_symbol),
      .left_handle_i  (left_handle),
      .right_weight_i (right_weight),
      .right_symbol_i (right_symbol),
      .right_handle_i (right_handle),
      .move_o         (move_chain[i]),
      .weight_o       (weight_chain[i]),
      .symbol_o       (symbol_chain[i]),
      .handle_o       (handle_chain[i])
    );
  end

  // Count and result for the request taken this cycle.
  always_comb begin
    count_d      = count_q;
    status_d     = STATUS_OK;
    res_weight_d = '0;
    res_symbol_d = '0;
    res_handle_d = '0;
    if (accept) begin
      if (op_i == OP_INSERT) begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          count_d = count_q + CountOne;
        end
      end else begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          count_d      = count_q - CountOne;
          res_weight_d = weight_chain[0];
          res_symbol_d = symbol_chain[0];
          res_handle_d = handle_chain[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    res_weight_q <= res_weight_d;
    res_symbol_q <= res_symbol_d;
    res_handle_q <= res_handle_d;
  end

  // The count register already holds the state after the reported request.
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_weight_o  = res_weight_q;
  assign out_symbol_o  = res_symbol_q;
  assign out_handle_o  = res_handle_q;
  assign occupancy_o   = count_q;
  assign is_empty_o    = count_q == '0;
  assign size_is_one_o = count_q == CountOne;

  `SPQ_ASSERT(a_done_follows_request, clk_i, rst_ni, accept |=> done_o)
  `SPQ_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= CountFull)
  `SPQ_ASSERT(a_empty_status_count, clk_i, rst_ni,
              (done_o && status_o == STATUS_EMPTY) |-> (count_q == '0))
  `SPQ_ASSERT(a_full_status_count, clk_i, rst_ni,
              (done_o && status_o == STATUS_FULL) |-> (count_q == CountFull))
  `SPQ_ASSERT(a_count_steady_idle, clk_i, rst_ni, !accept |=> $stable(count_q))

endmodule

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry and trades it with its
// neighbours on insert and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX         = 0,
  parameter int CNT_BITS    = 9,
  parameter int WEIGHT_BITS = 32,
  parameter int HANDLE_BITS = 9
) (
  input  wire logic                   clk_i,
  input  wire cell_ctrl_t             ctrl_i,
  input  wire logic [CNT_BITS-1:0]    count_i,
  input  wire logic [WEIGHT_BITS-1:0] new_weight_i,
  input  wire logic [7:0]             new_symbol_i,
  input  wire logic [HANDLE_BITS-1:0] new_handle_i,
  input  wire logic                   left_move_i,
  input  wire logic [WEIGHT_BITS-1:0] left_weight_i,
  input  wire logic [7:0]             left_symbol_i,
  input  wire logic [HANDLE_BITS-1:0] left_handle_i,
  input  wire logic [WEIGHT_BITS-1:0] right_weight_i,
  input  wire logic [7:0]             right_symbol_i,
  input  wire logic [HANDLE_BITS-1:0] right_handle_i,
  output logic                        move_o,
  output logic [WEIGHT_BITS-1:0]      weight_o,
  output logic [7:0]                  symbol_o,
  output logic [HANDLE_BITS-1:0]      handle_o
);

  logic [WEIGHT_BITS-1:0] weight_q, weight_d;
  logic [7:0]             symbol_q, symbol_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   occupied;

  assign occupied = CNT_BITS'(IDX) < count_i;

  // The new key goes ahead of this entry when it is strictly smaller, or
  // when the slot is empty.
  always_comb begin
    if (!occupied) begin
      move_o = 1'b1;
    end else if (new_weight_i < weight_q) begin
      move_o = 1'b1;
    end else if (new_weight_i == weight_q) begin
      move_o = new_symbol_i < symbol_q;
    end else begin
      move_o = 1'b0;
    end
  end

  always_comb begin
    weight_d = weight_q;
    symbol_d = symbol_q;
    handle_d = handle_q;
    if (ctrl_i.remove) begin
      weight_d = right_weight_i;
      symbol_d = right_symbol_i;
      handle_d = right_handle_i;
    end else if (ctrl_i.insert && move_o) begin
      if (left_move_i) begin
        weight_d = left_weight_i;
        symbol_d = left_symbol_i;
        handle_d = left_handle_i;
      end else begin
        weight_d = new_weight_i;
        symbol_d = new_symbol_i;
        handle_d = new_handle_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q <= weight_d;
    symbol_q <= symbol_d;
    handle_q <= handle_d;
  end

  assign weight_o = weight_q;
  assign symbol_o = symbol_q;
  assign handle_o = handle_q;

endmodule

`default_nettype wire
